// File: design/tfa_pkg.sv
// Package: opcodes, status codes, tags and stage payload types for the tagged fixnum ALU.
package tfa_pkg;

	localparam int OP_W   = 4;
	localparam int WORD_W = 32;
	localparam int ST_W   = 2;
	localparam int FIX_W  = 29;
	localparam int TAG_W  = 3;
	localparam int QUO_W  = 29;
	// decode register, operand/multiply register, one register per quotient bit
	localparam int PIPE_DEPTH = QUO_W + 2;

	localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL    = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
	localparam logic [OP_W-1:0] OP_REM    = 4'd4;
	localparam logic [OP_W-1:0] OP_LT     = 4'd5;
	localparam logic [OP_W-1:0] OP_EQ     = 4'd6;
	localparam logic [OP_W-1:0] OP_NULL   = 4'd7;
	localparam logic [OP_W-1:0] OP_BOOLP  = 4'd8;
	localparam logic [OP_W-1:0] OP_ISCHAR = 4'd9;
	localparam logic [OP_W-1:0] OP_SYMP   = 4'd10;
	localparam logic [OP_W-1:0] OP_ISPAIR = 4'd11;
	localparam logic [OP_W-1:0] OP_FIXP   = 4'd12;
	localparam logic [OP_W-1:0] OP_PIDP   = 4'd13;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_TYPE    = 2'd1;
	localparam logic [ST_W-1:0] ST_OVF     = 2'd2;
	localparam logic [ST_W-1:0] ST_DIVZERO = 2'd3;

	localparam logic [TAG_W-1:0] TAG_PAIR   = 3'd0;
	localparam logic [TAG_W-1:0] TAG_FIXNUM = 3'd2;
	localparam logic [TAG_W-1:0] TAG_BOOL   = 3'd3;
	localparam logic [TAG_W-1:0] TAG_SYMBOL = 3'd4;
	localparam logic [TAG_W-1:0] TAG_PID    = 3'd5;

	localparam logic [WORD_W-1:0] WORD_NIL   = 32'd1;
	localparam logic [WORD_W-1:0] WORD_FALSE = 32'd3;
	localparam logic [WORD_W-1:0] WORD_TRUE  = 32'd11;
	localparam int CHAR_LIMIT = 256;

	// result selector decided at decode
	localparam logic [2:0] SEL_FIXED = 3'd0;
	localparam logic [2:0] SEL_ADD   = 3'd1;
	localparam logic [2:0] SEL_MUL   = 3'd2;
	localparam logic [2:0] SEL_DIV   = 3'd3;
	localparam logic [2:0] SEL_REM   = 3'd4;

	// decoded item carried down the pipeline
	typedef struct packed {
		logic [2:0]        sel;
		logic [ST_W-1:0]   st;
		logic [WORD_W-1:0] word;
		logic signed [FIX_W:0] sum;
		logic signed [FIX_W-1:0] x;
		logic signed [FIX_W-1:0] y;
	} dec_t;

	function automatic logic [WORD_W-1:0] truth(input logic f);
		return f ? WORD_TRUE : WORD_FALSE;
	endfunction

	// entag a value, or flag overflow
	function automatic logic [WORD_W+ST_W-1:0] pack_fix(input logic signed [63:0] v);
		logic [WORD_W-1:0] w;
		w = {v[FIX_W-1:0], TAG_FIXNUM};
		if (v > 64'sd268435455 || v < -64'sd268435456)
			return {{WORD_W{1'b0}}, ST_OVF};
		return {w, ST_OK};
	endfunction

endpackage

// File: design/tfa_if.sv
// Interfaces: valid/ready channels for ALU operations and results.
interface tfa_op_if;
	logic valid;
	logic ready;
	logic [tfa_pkg::OP_W-1:0] op;
	logic [tfa_pkg::WORD_W-1:0] left_word;
	logic [tfa_pkg::WORD_W-1:0] right_word;
	modport source (output valid, op, left_word, right_word, input ready);
	modport sink (input valid, op, left_word, right_word, output ready);
endinterface

interface tfa_res_if;
	logic valid;
	logic ready;
	logic [tfa_pkg::WORD_W-1:0] result_word;
	logic [tfa_pkg::ST_W-1:0] status;
	modport source (output valid, result_word, status, input ready);
	modport sink (input valid, result_word, status, output ready);
endinterface

// File: design/tagged_fixnum_alu.sv
// Top level: pipelined tagged fixnum ALU.
//  channel | dir | fields
//  req     | in  | op, left_word, right_word
//  rsp     | out | result_word, status
// Every item passes PIPE_DEPTH (31) stage registers plus the output register: one
// decode register, an operand/multiply register, 29 division steps of one quotient
// bit each, then sign/pack logic into the output register. One item enters per cycle
// while rsp is not stalled. arst_n clears all valid bits.
// A stall on rsp freezes the whole pipeline; nothing is lost or repeated.
module tagged_fixnum_alu (
	input logic clk,
	input logic arst_n,
	tfa_op_if.sink   req,
	tfa_res_if.source rsp
);
	localparam int QW = tfa_pkg::QUO_W;
	localparam int PipeDepth = tfa_pkg::PIPE_DEPTH;

	logic adv;
	tfa_pkg::dec_t dec;
	logic [PipeDepth-1:0] vld_q;
	tfa_pkg::dec_t d_s1;
	logic [QW-1:0] rem_q [0:QW];
	logic [QW-1:0] quo_q [0:QW];
	logic [QW-1:0] dvd_q [0:QW-1];
	logic [QW-1:0] dvs_q [0:QW-1];
	tfa_pkg::dec_t dq [0:QW];
	logic signed [63:0] pq [0:QW];
	logic [QW-1:0] rn [0:QW-1];
	logic [QW-1:0] qn [0:QW-1];
	logic [tfa_pkg::WORD_W+tfa_pkg::ST_W-1:0] fin;
	logic signed [63:0] qv, rv;

	assign adv = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	tfa_decode u_dec (.op(req.op), .a(req.left_word), .b(req.right_word), .d(dec));

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rsp.valid <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[PipeDepth-2:0], req.valid};
			rsp.valid <= vld_q[PipeDepth-1];
		end
	end

	// stage 1 and 2: decode register, multiplier
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1 <= dec;
			dq[0] <= d_s1;
			pq[0] <= 64'(d_s1.x) * 64'(d_s1.y);
			rem_q[0] <= '0;
			quo_q[0] <= '0;
			dvd_q[0] <= d_s1.x[QW-1] ? QW'(-d_s1.x) : QW'(d_s1.x);
			dvs_q[0] <= d_s1.y[QW-1] ? QW'(-d_s1.y) : QW'(d_s1.y);
		end
	end

	// division steps, most significant quotient bit first
	for (genvar i = 0; i < QW; i++) begin : g_div
		tfa_div_stage #(.Bit(QW-1-i)) u_st (
			.rem_in(rem_q[i]), .quo_in(quo_q[i]), .dvd(dvd_q[i]), .dvs(dvs_q[i]),
			.rem_out(rn[i]), .quo_out(qn[i])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[i+1] <= rn[i];
				quo_q[i+1] <= qn[i];
				dq[i+1] <= dq[i];
				pq[i+1] <= pq[i];
			end
		end
		// carry the operands on to the next step only
		if (i < QW-1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (adv) begin
					dvd_q[i+1] <= dvd_q[i];
					dvs_q[i+1] <= dvs_q[i];
				end
			end
		end
	end

	// apply signs and pack the result
	always_comb begin
		qv = 64'($signed({1'b0, quo_q[QW]}));
		rv = 64'($signed({1'b0, rem_q[QW]}));
		if (dq[QW].x[QW-1] ^ dq[QW].y[QW-1]) qv = -qv;
		if (dq[QW].x[QW-1]) rv = -rv;
		case (dq[QW].sel)
		tfa_pkg::SEL_ADD: fin = tfa_pkg::pack_fix(64'(dq[QW].sum));
		tfa_pkg::SEL_MUL: fin = tfa_pkg::pack_fix(pq[QW]);
		tfa_pkg::SEL_DIV: fin = tfa_pkg::pack_fix(qv);
		tfa_pkg::SEL_REM: fin = tfa_pkg::pack_fix(rv);
		default:          fin = {dq[QW].word, dq[QW].st};
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.result_word <= fin[tfa_pkg::ST_W +: tfa_pkg::WORD_W];
			rsp.status <= fin[tfa_pkg::ST_W-1:0];
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_word))
		else $error("result changed under stall");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != tfa_pkg::ST_OK |-> rsp.result_word == '0)
		else $error("nonzero word with error status");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!rsp.valid || rsp.ready))
		else $error("ready mismatch");
`endif
endmodule

// File: design/tfa_decode.sv
// Decode stage: tag checks, predicates, add/sub and operand extraction.
module tfa_decode (
	input  logic [tfa_pkg::OP_W-1:0]   op,
	input  logic [tfa_pkg::WORD_W-1:0] a,
	input  logic [tfa_pkg::WORD_W-1:0] b,
	output tfa_pkg::dec_t              d
);
	logic afix, bfix;
	logic signed [tfa_pkg::FIX_W-1:0] x, y;

	assign afix = a[2:0] == tfa_pkg::TAG_FIXNUM;
	assign bfix = b[2:0] == tfa_pkg::TAG_FIXNUM;
	assign x = a[31:3];
	assign y = b[31:3];

	// classify the item and settle the direct results
	always_comb begin
		d.sel = tfa_pkg::SEL_FIXED;
		d.st = tfa_pkg::ST_OK;
		d.word = '0;
		d.x = x;
		d.y = y;
		d.sum = (op == tfa_pkg::OP_SUB) ? (30'(x) - 30'(y)) : (30'(x) + 30'(y));
		case (op)
		tfa_pkg::OP_ADD, tfa_pkg::OP_SUB, tfa_pkg::OP_MUL, tfa_pkg::OP_LT: begin
			if (!afix || !bfix)
				d.st = tfa_pkg::ST_TYPE;
			else if (op == tfa_pkg::OP_LT)
				d.word = tfa_pkg::truth(x < y);
			else if (op == tfa_pkg::OP_MUL)
				d.sel = tfa_pkg::SEL_MUL;
			else
				d.sel = tfa_pkg::SEL_ADD;
		end
		tfa_pkg::OP_DIV, tfa_pkg::OP_REM: begin
			if (!bfix)
				d.st = tfa_pkg::ST_TYPE;
			else if (y == '0)
				d.st = tfa_pkg::ST_DIVZERO;
			else if (!afix)
				d.st = tfa_pkg::ST_TYPE;
			else
				d.sel = (op == tfa_pkg::OP_DIV) ? tfa_pkg::SEL_DIV : tfa_pkg::SEL_REM;
		end
		tfa_pkg::OP_EQ:     d.word = tfa_pkg::truth(a == b);
		tfa_pkg::OP_NULL:   d.word = tfa_pkg::truth(a == tfa_pkg::WORD_NIL);
		tfa_pkg::OP_BOOLP:  d.word = tfa_pkg::truth(a[2:0] == tfa_pkg::TAG_BOOL);
		tfa_pkg::OP_ISCHAR: d.word = tfa_pkg::truth(afix && a[31:3] < 29'(tfa_pkg::CHAR_LIMIT));
		tfa_pkg::OP_SYMP:   d.word = tfa_pkg::truth(a[2:0] == tfa_pkg::TAG_SYMBOL);
		tfa_pkg::OP_ISPAIR: d.word = tfa_pkg::truth(a[2:0] == tfa_pkg::TAG_PAIR);
		tfa_pkg::OP_FIXP:   d.word = tfa_pkg::truth(afix);
		tfa_pkg::OP_PIDP:   d.word = tfa_pkg::truth(a[2:0] == tfa_pkg::TAG_PID);
		default:            d.st = tfa_pkg::ST_TYPE;
		endcase
	end
endmodule

// File: design/tfa_div_stage.sv
// One restoring division step on magnitudes, one quotient bit per stage.
module tfa_div_stage #(
	parameter int Bit = 0
) (
	input  logic [tfa_pkg::QUO_W-1:0] rem_in,
	input  logic [tfa_pkg::QUO_W-1:0] quo_in,
	input  logic [tfa_pkg::QUO_W-1:0] dvd,
	input  logic [tfa_pkg::QUO_W-1:0] dvs,
	output logic [tfa_pkg::QUO_W-1:0] rem_out,
	output logic [tfa_pkg::QUO_W-1:0] quo_out
);
	logic [tfa_pkg::QUO_W:0] trial;

	// shift in the next dividend bit and try to subtract
	always_comb begin
		trial = {rem_in, dvd[Bit]};
		quo_out = quo_in;
		if (trial >= {1'b0, dvs}) begin
			rem_out = tfa_pkg::QUO_W'(trial - {1'b0, dvs});
			quo_out[Bit] = 1'b1;
		end else begin
			rem_out = trial[tfa_pkg::QUO_W-1:0];
		end
	end
endmodule

// File: tb/tagged_fixnum_alu_checker.sv
// Checker: watches the operation and result channels, predicts each result and compares.
`timescale 1ns / 1ps
module tagged_fixnum_alu_checker (
	input logic clk,
	input logic arst_n,
	tfa_op_if req,
	tfa_res_if rsp,
	output int fail_count,
	output int pending
);
	import tfa_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [ST_W-1:0]   st;
	} alu_result_t;

	alu_result_t awaited_results[$];

	function automatic logic has_fix_tag(input logic [WORD_W-1:0] w);
		return w[TAG_W-1:0] == TAG_FIXNUM;
	endfunction

	function automatic logic [WORD_W-1:0] as_bool(input logic f);
		return f ? WORD_TRUE : WORD_FALSE;
	endfunction

	function automatic alu_result_t entag(input longint v);
		alu_result_t r;
		logic [63:0] bits;
		bits = v;
		if (v > 64'sd268435455 || v < -64'sd268435456) begin
			r.word = '0;
			r.st = ST_OVF;
		end else begin
			r.word = {bits[FIX_W-1:0], TAG_FIXNUM};
			r.st = ST_OK;
		end
		return r;
	endfunction

	// work out the result of one operation
	function automatic alu_result_t compute_alu(input logic [OP_W-1:0] op,
			input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		alu_result_t r;
		longint x, y;
		x = longint'(signed'(a[WORD_W-1:TAG_W]));
		y = longint'(signed'(b[WORD_W-1:TAG_W]));
		r.word = '0;
		r.st = ST_OK;
		case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_LT: begin
				if (!has_fix_tag(a) || !has_fix_tag(b))
					r.st = ST_TYPE;
				else if (op == OP_ADD)
					r = entag(x + y);
				else if (op == OP_SUB)
					r = entag(x - y);
				else if (op == OP_MUL)
					r = entag(x * y);
				else
					r.word = as_bool(x < y);
			end
			OP_DIV, OP_REM: begin
				if (!has_fix_tag(b))
					r.st = ST_TYPE;
				else if (y == 0)
					r.st = ST_DIVZERO;
				else if (!has_fix_tag(a))
					r.st = ST_TYPE;
				else if (op == OP_DIV)
					r = entag(x / y);
				else
					r = entag(x % y);
			end
			OP_EQ:     r.word = as_bool(a == b);
			OP_NULL:   r.word = as_bool(a == WORD_NIL);
			OP_BOOLP:  r.word = as_bool(a[TAG_W-1:0] == TAG_BOOL);
			OP_ISCHAR: r.word = as_bool(has_fix_tag(a) && a[WORD_W-1:TAG_W] < CHAR_LIMIT);
			OP_SYMP:   r.word = as_bool(a[TAG_W-1:0] == TAG_SYMBOL);
			OP_ISPAIR: r.word = as_bool(a[TAG_W-1:0] == TAG_PAIR);
			OP_FIXP:   r.word = as_bool(has_fix_tag(a));
			OP_PIDP:   r.word = as_bool(a[TAG_W-1:0] == TAG_PID);
			default:   r.st = ST_TYPE;
		endcase
		return r;
	endfunction

	// predict on accepted operations, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		alu_result_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			awaited_results.delete();
		end else begin
			if (req.valid && req.ready)
				awaited_results.push_back(compute_alu(req.op, req.left_word, req.right_word));
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result item: result_word %h status %0d",
						rsp.result_word, rsp.status);
					errs = errs + 1;
				end else begin
					want = awaited_results.pop_front();
					if (rsp.result_word !== want.word) begin
						$error("result_word: expected %h, got %h", want.word, rsp.result_word);
						errs = errs + 1;
					end
					if (rsp.status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, rsp.status);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending <= awaited_results.size();
		end
	end
endmodule

// File: tb/tagged_fixnum_alu_tb.sv
// Testbench top: clock, reset, operation stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module tagged_fixnum_alu_tb;
	import tfa_pkg::*;

	localparam int RANDOM_ITEMS = 630;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending;
	int quiet_cycles = 0;
	logic steady;

	tfa_op_if req();
	tfa_res_if rsp();

	tagged_fixnum_alu i_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	tagged_fixnum_alu_checker i_checker (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// make a fixnum word from a value
	function automatic logic [WORD_W-1:0] fix(input int v);
		logic [31:0] bits;
		bits = v;
		return {bits[FIX_W-1:0], TAG_FIXNUM};
	endfunction

	// random operand: mostly fixnums, small ones often
	function automatic logic [WORD_W-1:0] rand_operand();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			return fix($urandom_range(0, 20) - 10);
		if (pick < 4)
			return fix($urandom_range(0, 300));
		if (pick < 7)
			return {$urandom_range(0, 1) ? 29'h0FFFFFFF : 29'h10000000, TAG_FIXNUM} ^
				{29'($urandom_range(0, 15)), 3'b000};
		if (pick < 8)
			return {29'($urandom()), TAG_FIXNUM};
		if (pick < 9)
			return $urandom_range(0, 1) ? WORD_NIL : WORD_TRUE;
		return $urandom();
	endfunction

	// offer one item and hold it until accepted
	task automatic send(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		while (!steady && $urandom_range(0, 99) < 13) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.left_word <= a;
		req.right_word <= b;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	// randomly stall the result side, except in the steady stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= steady || ($urandom_range(0, 99) >= 13);
	end

	// watchdog on progress
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tagged_fixnum_alu_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		logic [OP_W-1:0] op;
		steady = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = '0;
		req.left_word = '0;
		req.right_word = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, overflow, division checks, predicates, undefined opcodes
		send(OP_ADD, fix(268435455), fix(1));
		send(OP_ADD, fix(-268435456), fix(-1));
		send(OP_SUB, fix(-268435456), fix(1));
		send(OP_MUL, fix(16384), fix(16384));
		send(OP_MUL, fix(-268435456), fix(-1));
		send(OP_DIV, fix(-268435456), fix(-1));
		send(OP_DIV, fix(-7), fix(2));
		send(OP_REM, fix(-7), fix(2));
		send(OP_DIV, WORD_NIL, fix(0));
		send(OP_REM, WORD_NIL, WORD_TRUE);
		send(OP_DIV, WORD_NIL, fix(3));
		send(OP_LT, fix(-1), fix(0));
		send(OP_LT, WORD_NIL, fix(0));
		send(OP_EQ, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send(OP_EQ, 32'h0, 32'h1);
		send(OP_NULL, WORD_NIL, '0);
		send(OP_NULL, 32'h9, '0);
		send(OP_BOOLP, WORD_FALSE, '0);
		send(OP_ISCHAR, fix(255), '0);
		send(OP_ISCHAR, fix(256), '0);
		send(OP_ISCHAR, fix(-1), '0);
		send(OP_SYMP, 32'h4, '0);
		send(OP_ISPAIR, 32'h0, '0);
		send(OP_FIXP, fix(5), '0);
		send(OP_PIDP, 32'hFFFFFFFD, '0);
		send(4'd14, fix(1), fix(1));
		send(4'd15, fix(1), fix(1));

		// hold off until every result is back
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);

		// random operations, with a steady stretch in the middle
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 250 && n < 350);
			op = OP_W'($urandom_range(0, 15));
			send(op, rand_operand(), rand_operand());
		end
		steady = 1'b0;
		req.valid <= 1'b0;

		// drain, then allow the pipeline latency to pass
		while (pending != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (fail_count == 0)
			$display("tagged_fixnum_alu_tb: clean");
		else
			$display("tagged_fixnum_alu_tb: errors");
		$finish;
	end
endmodule

// File: tagged_fixnum_alu.f
design/tfa_pkg.sv
design/tfa_if.sv
design/tfa_decode.sv
design/tfa_div_stage.sv
design/tagged_fixnum_alu.sv
tb/tagged_fixnum_alu_checker.sv
tb/tagged_fixnum_alu_tb.sv
